// File: hw/rtl/dp3d_pkg.sv
package dp3d_pkg;

    // Field geometry
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int DEPTH_W    = 16;
    localparam int CTR_W      = COORD_BITS + 4;
    localparam int FOC_W      = 16;
    localparam int FW_W       = COORD_BITS + 1;
    localparam int IDX_W      = 2 * COORD_BITS;
    localparam int Z_W        = 31;
    localparam int XY_W       = 32;
    localparam int ZDIV_W     = DEPTH_W + FRAC_BITS;
    localparam int PROD_W     = CTR_W + Z_W;
    localparam int DIV_W      = (PROD_W > ZDIV_W) ? PROD_W : ZDIV_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_FOCAL_X     = 3'd2,
        REG_FOCAL_Y     = 3'd3,
        REG_DEPTH_SCALE = 3'd4,
        REG_FRAME_WIDTH = 3'd5
    } t_reg_idx;

    // Reset values
    localparam logic [CTR_W-1:0]   RST_CENTER_X    = CTR_W'(5090);
    localparam logic [CTR_W-1:0]   RST_CENTER_Y    = CTR_W'(3725);
    localparam logic [FOC_W-1:0]   RST_FOCAL_X     = FOC_W'(8382);
    localparam logic [FOC_W-1:0]   RST_FOCAL_Y     = FOC_W'(8387);
    localparam logic [FOC_W-1:0]   RST_DEPTH_SCALE = FOC_W'(1000);
    localparam logic [FW_W-1:0]    RST_FRAME_WIDTH = FW_W'(640);

    // Sideband that rides beside the depth divider
    typedef struct packed {
        logic                  v;
        logic                  nz;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [IDX_W-1:0]      idx;
    } t_sb_a;

    // Sideband that rides beside the lateral dividers
    typedef struct packed {
        logic             v;
        logic             nz;
        logic             nx;
        logic             ny;
        logic [Z_W-1:0]   z;
        logic [IDX_W-1:0] idx;
    } t_sb_b;

endpackage

// File: hw/rtl/dp3d_if.sv
interface dp3d_pix_if;
    logic                              valid;
    logic                              ready;
    logic [dp3d_pkg::COORD_BITS-1:0]   pixel_column;
    logic [dp3d_pkg::COORD_BITS-1:0]   pixel_row;
    logic [dp3d_pkg::DEPTH_W-1:0]      depth_raw;
    modport source (output valid, pixel_column, pixel_row, depth_raw, input ready);
    modport sink   (input valid, pixel_column, pixel_row, depth_raw, output ready);
endinterface

interface dp3d_pt_if;
    logic                          valid;
    logic                          ready;
    logic signed [dp3d_pkg::XY_W-1:0] point_x;
    logic signed [dp3d_pkg::XY_W-1:0] point_y;
    logic [dp3d_pkg::Z_W-1:0]      point_z;
    logic                          point_valid;
    logic [dp3d_pkg::IDX_W-1:0]    point_index;
    modport source (output valid, point_x, point_y, point_z, point_valid, point_index,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_valid, point_index,
                    output ready);
endinterface

interface dp3d_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dp3d_pkg::CFG_IDX_W-1:0]    index;
    logic [dp3d_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/dp3d_div.sv
module dp3d_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [dp3d_pkg::DIV_W-1:0]    i_dividend,
    input  logic [dp3d_pkg::FOC_W-1:0]    i_divisor,
    output logic [dp3d_pkg::DIV_W-1:0]    o_quotient
);

    localparam int W  = dp3d_pkg::DIV_W;
    localparam int DW = dp3d_pkg::FOC_W;

    // One quotient bit per stage: dividend bits shift out the top, quotient bits in
    logic [DW-1:0] r_rem [W];
    logic [W-1:0]  r_dq  [W];
    logic [DW-1:0] r_dvs [W];
    logic [DW-1:0] n_rem [W];
    logic [W-1:0]  n_dq  [W];

    genvar g;
    generate
        for (g = 0; g < W; g++) begin : g_stage
            logic [DW-1:0] p_rem;
            logic [W-1:0]  p_dq;
            logic [DW-1:0] p_dvs;
            logic [DW:0]   t;
            logic          ge;

            if (g == 0) begin : g_first
                assign p_rem = '0;
                assign p_dq  = i_dividend;
                assign p_dvs = i_divisor;
            end else begin : g_next
                assign p_rem = r_rem[g-1];
                assign p_dq  = r_dq[g-1];
                assign p_dvs = r_dvs[g-1];
            end

            // Trial subtract
            always_comb begin
                t        = {p_rem, p_dq[W-1]};
                ge       = (t >= {1'b0, p_dvs});
                n_rem[g] = ge ? DW'(t - {1'b0, p_dvs}) : t[DW-1:0];
                n_dq[g]  = {p_dq[W-2:0], ge};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem[g];
                    r_dq[g]  <= n_dq[g];
                    r_dvs[g] <= p_dvs;
                end
            end
        end
    endgenerate

    assign o_quotient = r_dq[W-1];

endmodule

// File: hw/rtl/depth_pixel_to_3d_point.sv
// Depth pixel to 3D point, pinhole back-projection.
// i_pix carries one depth pixel a beat (column, row, raw depth); o_pt returns one
// point a beat (x, y signed and z unsigned Q15.16 metres, valid flag, linear index).
// i_cfg writes the six camera registers by index; it is always ready and must be
// used only while no pixel is in flight.
// Throughput: one pixel per cycle while the receiver takes each point. The path runs
// through two chained bit-per-stage divider pipelines: one for z = depth/scale and
// one pair for x and y (product over focal length).
// Zero depth gives x = y = z = 0 with point_valid low; the index is still given.
// Reset clears all pipeline valid bits and loads the default camera registers.
// When the receiver stalls, the whole pipeline holds; i_pix.ready drops only
// while a finished point waits in the output register and is not taken, so no
// beat is lost or repeated.
module depth_pixel_to_3d_point (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dp3d_pix_if.sink          i_pix,
    dp3d_cfg_if.sink          i_cfg,
    dp3d_pt_if.source         o_pt
);

    localparam int W   = dp3d_pkg::DIV_W;
    localparam int CB  = dp3d_pkg::COORD_BITS;
    localparam int CW  = dp3d_pkg::CTR_W;
    localparam int FW  = dp3d_pkg::FOC_W;
    localparam int ZW  = dp3d_pkg::Z_W;
    localparam int XW  = dp3d_pkg::XY_W;
    localparam int IW  = dp3d_pkg::IDX_W;
    localparam int PW  = dp3d_pkg::PROD_W;
    localparam logic [W-1:0] Z_LIM   = W'({ZW{1'b1}});
    localparam logic [W-1:0] POS_LIM = W'({(XW-1){1'b1}});
    localparam logic [W-1:0] NEG_LIM = W'(1) << (XW - 1);

    // Configuration registers
    logic [CW-1:0]                  r_center_x, r_center_y;
    logic [FW-1:0]                  r_focal_x, r_focal_y, r_depth_scale;
    logic [dp3d_pkg::FW_W-1:0]      r_frame_width;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= dp3d_pkg::RST_CENTER_X;
            r_center_y    <= dp3d_pkg::RST_CENTER_Y;
            r_focal_x     <= dp3d_pkg::RST_FOCAL_X;
            r_focal_y     <= dp3d_pkg::RST_FOCAL_Y;
            r_depth_scale <= dp3d_pkg::RST_DEPTH_SCALE;
            r_frame_width <= dp3d_pkg::RST_FRAME_WIDTH;
        end else if (i_cfg.valid) begin
            case (dp3d_pkg::t_reg_idx'(i_cfg.index))
                dp3d_pkg::REG_CENTER_X:    r_center_x    <= i_cfg.data[CW-1:0];
                dp3d_pkg::REG_CENTER_Y:    r_center_y    <= i_cfg.data[CW-1:0];
                dp3d_pkg::REG_FOCAL_X:     r_focal_x     <= i_cfg.data[FW-1:0];
                dp3d_pkg::REG_FOCAL_Y:     r_focal_y     <= i_cfg.data[FW-1:0];
                dp3d_pkg::REG_DEPTH_SCALE: r_depth_scale <= i_cfg.data[FW-1:0];
                dp3d_pkg::REG_FRAME_WIDTH:
                    r_frame_width <= i_cfg.data[dp3d_pkg::FW_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero divisors act as one
    logic [FW-1:0] scale_nz, fx_nz, fy_nz;
    assign scale_nz = (r_depth_scale == '0) ? FW'(1) : r_depth_scale;
    assign fx_nz    = (r_focal_x == '0) ? FW'(1) : r_focal_x;
    assign fy_nz    = (r_focal_y == '0) ? FW'(1) : r_focal_y;

    // Global advance: hold everything while a finished point is not taken
    logic r_out_valid;
    logic en;
    assign en          = !r_out_valid || o_pt.ready;
    assign i_pix.ready = en;

    // Stage 0: input register
    logic                          r_v0;
    logic [CB-1:0]                 r_col0, r_row0;
    logic [dp3d_pkg::DEPTH_W-1:0]  r_dep0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col0 <= i_pix.pixel_column;
            r_row0 <= i_pix.pixel_row;
            r_dep0 <= i_pix.depth_raw;
        end
    end

    // Depth divider and its sideband line
    dp3d_pkg::t_sb_a sb_a_in;
    dp3d_pkg::t_sb_a r_dl_a [W];
    logic [W-1:0]    z_dividend, zq;

    always_comb begin
        sb_a_in.v   = r_v0;
        sb_a_in.nz  = (r_dep0 != '0);
        sb_a_in.col = r_col0;
        sb_a_in.row = r_row0;
        sb_a_in.idx = IW'(r_row0 * r_frame_width + (dp3d_pkg::FW_W + CB)'(r_col0));
        z_dividend  = W'({r_dep0, {dp3d_pkg::FRAC_BITS{1'b0}}});
    end

    dp3d_div u_div_z (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (z_dividend),
        .i_divisor  (scale_nz),
        .o_quotient (zq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < W; i++) r_dl_a[i] <= '0;
        end else if (en) begin
            r_dl_a[0] <= sb_a_in;
            for (int i = 1; i < W; i++) r_dl_a[i] <= r_dl_a[i-1];
        end
    end

    // Stage 1: saturate z, take offsets from the optical center
    dp3d_pkg::t_sb_a sb_a_out;
    logic [ZW-1:0]   n_z1;
    logic [CW-1:0]   sc_x, sc_y, n_dx1, n_dy1;
    logic            n_nx1, n_ny1;
    logic [ZW-1:0]   r_z1;
    logic [CW-1:0]   r_dx1, r_dy1;
    logic            r_nx1, r_ny1, r_v1, r_nz1;
    logic [IW-1:0]   r_idx1;

    always_comb begin
        sb_a_out = r_dl_a[W-1];
        n_z1     = (zq > Z_LIM) ? {ZW{1'b1}} : zq[ZW-1:0];
        sc_x     = {sb_a_out.col, 4'b0000};
        sc_y     = {sb_a_out.row, 4'b0000};
        n_nx1    = sc_x < r_center_x;
        n_ny1    = sc_y < r_center_y;
        n_dx1    = n_nx1 ? (r_center_x - sc_x) : (sc_x - r_center_x);
        n_dy1    = n_ny1 ? (r_center_y - sc_y) : (sc_y - r_center_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= sb_a_out.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z1   <= n_z1;
            r_dx1  <= n_dx1;
            r_dy1  <= n_dy1;
            r_nx1  <= n_nx1;
            r_ny1  <= n_ny1;
            r_nz1  <= sb_a_out.nz;
            r_idx1 <= sb_a_out.idx;
        end
    end

    // Stage 2: offset times z
    logic [PW-1:0]   r_px2, r_py2;
    dp3d_pkg::t_sb_b r_sb2;
    dp3d_pkg::t_sb_b n_sb2;

    always_comb begin
        n_sb2.v   = r_v1;
        n_sb2.nz  = r_nz1;
        n_sb2.nx  = r_nx1;
        n_sb2.ny  = r_ny1;
        n_sb2.z   = r_z1;
        n_sb2.idx = r_idx1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb2 <= '0;
        end else if (en) begin
            r_sb2 <= n_sb2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px2 <= PW'(r_dx1) * PW'(r_z1);
            r_py2 <= PW'(r_dy1) * PW'(r_z1);
        end
    end

    // Lateral dividers and their sideband line
    logic [W-1:0]    xq, yq;
    dp3d_pkg::t_sb_b r_dl_b [W];

    dp3d_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (W'(r_px2)),
        .i_divisor  (fx_nz),
        .o_quotient (xq)
    );

    dp3d_div u_div_y (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (W'(r_py2)),
        .i_divisor  (fy_nz),
        .o_quotient (yq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < W; i++) r_dl_b[i] <= '0;
        end else if (en) begin
            r_dl_b[0] <= r_sb2;
            for (int i = 1; i < W; i++) r_dl_b[i] <= r_dl_b[i-1];
        end
    end

    // Stage 3: apply sign, saturate, output register
    dp3d_pkg::t_sb_b sb_b_out;
    logic [XW-1:0]   mag_x, mag_y, n_x, n_y;
    logic [XW-1:0]   r_x, r_y;
    logic [ZW-1:0]   r_z;
    logic            r_pv;
    logic [IW-1:0]   r_idx;

    always_comb begin
        sb_b_out = r_dl_b[W-1];
        if (sb_b_out.nx) begin
            mag_x = (xq > NEG_LIM) ? NEG_LIM[XW-1:0] : xq[XW-1:0];
            n_x   = XW'(0) - mag_x;
        end else begin
            mag_x = (xq > POS_LIM) ? POS_LIM[XW-1:0] : xq[XW-1:0];
            n_x   = mag_x;
        end
        if (sb_b_out.ny) begin
            mag_y = (yq > NEG_LIM) ? NEG_LIM[XW-1:0] : yq[XW-1:0];
            n_y   = XW'(0) - mag_y;
        end else begin
            mag_y = (yq > POS_LIM) ? POS_LIM[XW-1:0] : yq[XW-1:0];
            n_y   = mag_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sb_b_out.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= sb_b_out.z;
            r_pv  <= sb_b_out.nz;
            r_idx <= sb_b_out.idx;
        end
    end

    assign o_pt.valid       = r_out_valid;
    assign o_pt.point_x     = r_x;
    assign o_pt.point_y     = r_y;
    assign o_pt.point_z     = r_z;
    assign o_pt.point_valid = r_pv;
    assign o_pt.point_index = r_idx;

    // A point without a measurement carries zero coordinates
    a_nodepth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_pv) |-> (r_x == '0 && r_y == '0 && r_z == '0))
        else $error("no-depth point has nonzero coordinates");

    // Zero distance forces zero lateral offsets
    a_zero_z_lateral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_z == '0) |-> (r_x == '0 && r_y == '0))
        else $error("zero z with nonzero x or y");

    // A waiting point blocks intake
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pt.ready) |-> !i_pix.ready)
        else $error("input taken while output stalled");

    // A stalled output register holds its point
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pt.ready) |=> (r_out_valid && $stable(r_x) && $stable(r_idx)))
        else $error("stalled point changed");

endmodule

// File: sim/tb_if.sv
`timescale 1ns / 1ps

// The testbench reaches the block through the channel interfaces of hw/rtl/dp3d_if.sv.

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic signed [dp3d_pkg::XY_W-1:0] x;
        logic signed [dp3d_pkg::XY_W-1:0] y;
        logic [dp3d_pkg::Z_W-1:0]         z;
        logic                             pv;
        logic [dp3d_pkg::IDX_W-1:0]       idx;
    } t_point;

    localparam int LATENCY   = 2 * dp3d_pkg::DIV_W + 4;
    localparam int STALL_MAX = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dp3d_pix_if pix ();
    dp3d_pt_if  pt ();
    dp3d_cfg_if cfg ();

    depth_pixel_to_3d_point uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_pt    (pt)
    );

    always #10 i_clk = ~i_clk;

    // Camera registers as the block should hold them
    logic [dp3d_pkg::CTR_W-1:0] cam_cx;
    logic [dp3d_pkg::CTR_W-1:0] cam_cy;
    logic [dp3d_pkg::FOC_W-1:0] cam_fx;
    logic [dp3d_pkg::FOC_W-1:0] cam_fy;
    logic [dp3d_pkg::FOC_W-1:0] cam_scale;
    logic [dp3d_pkg::FW_W-1:0]  cam_width;

    t_point expected_points[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_sink = 1'b0;

    // Lateral coordinate: (coord*16 - centre) * z / focal, saturated
    function automatic logic signed [dp3d_pkg::XY_W-1:0] lateral_coord(
        input logic [dp3d_pkg::COORD_BITS-1:0] coord, input logic [dp3d_pkg::CTR_W-1:0] centre,
        input logic [63:0] z, input logic [dp3d_pkg::FOC_W-1:0] focal);
        logic [63:0] scaled;
        logic [63:0] diff;
        logic [63:0] mag;
        logic [63:0] div;
        scaled = 64'(coord) << 4;
        div = (focal == 0) ? 64'd1 : 64'(focal);
        if (scaled < centre) begin
            diff = 64'(centre) - scaled;
            mag = (diff * z) / div;
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return dp3d_pkg::XY_W'(64'h1_0000_0000 - mag);
        end
        diff = scaled - 64'(centre);
        mag = (diff * z) / div;
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return dp3d_pkg::XY_W'(mag);
    endfunction

    function automatic t_point project_pixel(input logic [dp3d_pkg::COORD_BITS-1:0] col,
                                             input logic [dp3d_pkg::COORD_BITS-1:0] row,
                                             input logic [dp3d_pkg::DEPTH_W-1:0] depth);
        t_point p;
        logic [63:0] z;
        logic [63:0] div;
        p = '0;
        if (depth != 0) begin
            div = (cam_scale == 0) ? 64'd1 : 64'(cam_scale);
            z = (64'(depth) << dp3d_pkg::FRAC_BITS) / div;
            if (z > 64'h7FFF_FFFF) z = 64'h7FFF_FFFF;
            p.z = dp3d_pkg::Z_W'(z);
            p.x = lateral_coord(col, cam_cx, z, cam_fx);
            p.y = lateral_coord(row, cam_cy, z, cam_fy);
            p.pv = 1'b1;
        end
        p.idx = dp3d_pkg::IDX_W'(64'(row) * 64'(cam_width) + 64'(col));
        return p;
    endfunction

    // Append one prediction at the tail of the queue
    function automatic void queue_point(input t_point p);
        expected_points = {expected_points, p};
    endfunction

    // Predict on every accepted pixel beat
    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready)
            queue_point(project_pixel(pix.pixel_column, pix.pixel_row, pix.depth_raw));
    end

    // Compare every accepted point beat with the oldest prediction
    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (i_rst_n && pt.valid && pt.ready) begin
            got = '{pt.point_x, pt.point_y, pt.point_z, pt.point_valid, pt.point_index};
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d z=%0d v=%0b idx=%0d",
                             got.x, got.y, got.z, got.pv, got.idx);
            end else begin
                want = expected_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch exp x=%0d y=%0d z=%0d v=%0b idx=%0d",
                                 want.x, want.y, want.z, want.pv, want.idx,
                                 "  got x=%0d y=%0d z=%0d v=%0b idx=%0d",
                                 got.x, got.y, got.z, got.pv, got.idx);
                end
            end
        end
    end

    // Receiver ready: random stalls, or held off entirely
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_sink)
            pt.ready <= 1'b0;
        else
            pt.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (pt.valid && pt.ready) || hold_sink)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        pix.valid = 1'b0;
        pix.pixel_column = '0;
        pix.pixel_row = '0;
        pix.depth_raw = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
    end

    // Offer one beat and hold it until taken; valid stays up for the next beat
    task automatic send_pixel(input logic [dp3d_pkg::COORD_BITS-1:0] col,
                              input logic [dp3d_pkg::COORD_BITS-1:0] row,
                              input logic [dp3d_pkg::DEPTH_W-1:0] depth);
        while ($urandom_range(99) < send_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.pixel_column <= col;
        pix.pixel_row <= row;
        pix.depth_raw <= depth;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    task automatic send_random_pixel();
        logic [dp3d_pkg::DEPTH_W-1:0] depth;
        case ($urandom_range(9))
            0: depth = '0;
            1: depth = dp3d_pkg::DEPTH_W'($urandom);
            default: depth = dp3d_pkg::DEPTH_W'($urandom_range(4000, 1));
        endcase
        send_pixel(dp3d_pkg::COORD_BITS'($urandom), dp3d_pkg::COORD_BITS'($urandom), depth);
    endtask

    // Drop valid and let the pipeline empty before touching a register
    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input dp3d_pkg::t_reg_idx idx,
                             input logic [dp3d_pkg::CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            dp3d_pkg::REG_CENTER_X:    cam_cx = dp3d_pkg::CTR_W'(value);
            dp3d_pkg::REG_CENTER_Y:    cam_cy = dp3d_pkg::CTR_W'(value);
            dp3d_pkg::REG_FOCAL_X:     cam_fx = value;
            dp3d_pkg::REG_FOCAL_Y:     cam_fy = value;
            dp3d_pkg::REG_DEPTH_SCALE: cam_scale = value;
            dp3d_pkg::REG_FRAME_WIDTH: cam_width = dp3d_pkg::FW_W'(value);
            default: ;
        endcase
    endtask

    task automatic write_camera(input int cx, input int cy, input int fx, input int fy,
                                input int scale, input int width);
        wait_drained();
        write_reg(dp3d_pkg::REG_CENTER_X, dp3d_pkg::CFG_DATA_W'(cx));
        write_reg(dp3d_pkg::REG_CENTER_Y, dp3d_pkg::CFG_DATA_W'(cy));
        write_reg(dp3d_pkg::REG_FOCAL_X, dp3d_pkg::CFG_DATA_W'(fx));
        write_reg(dp3d_pkg::REG_FOCAL_Y, dp3d_pkg::CFG_DATA_W'(fy));
        write_reg(dp3d_pkg::REG_DEPTH_SCALE, dp3d_pkg::CFG_DATA_W'(scale));
        write_reg(dp3d_pkg::REG_FRAME_WIDTH, dp3d_pkg::CFG_DATA_W'(width));
        cfg.valid <= 1'b0;
    endtask

    // Extremes of every field, no measurement, saturation, largest index
    task automatic test_directed();
        send_pixel(0, 0, 0);
        send_pixel(1023, 1023, 0);
        send_pixel(318, 232, 1000);
        send_pixel(0, 0, 1);
        send_pixel(1023, 1023, 16'hFFFF);
        send_pixel(0, 1023, 16'hFFFF);
        send_pixel(1023, 0, 16'h8000);
        send_pixel(10'h2AA, 10'h155, 16'h5555);
        send_pixel(10'h155, 10'h2AA, 16'hAAAA);
        // tiny scale and focal: z and x/y saturate, index reaches its largest value
        write_camera(16383, 0, 1, 1, 1, 1024);
        send_pixel(0, 1023, 16'hFFFF);
        send_pixel(1023, 0, 16'hFFFF);
        send_pixel(1023, 1023, 1);
        send_pixel(0, 0, 1);
        // zero divisors act as one
        write_camera(0, 16383, 0, 0, 0, 1);
        send_pixel(1023, 0, 16'h1234);
        send_pixel(0, 1023, 16'hFFFF);
        send_pixel(5, 7, 0);
        // large divisors
        write_camera(8000, 8000, 65535, 65535, 65535, 1023);
        send_pixel(1023, 1023, 16'hFFFF);
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(512, 500, 1);
    endtask

    task automatic test_random_phase(input int n, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) send_random_pixel();
    endtask

    // Hold the receiver off so the pipeline fills and stalls its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sink = 1'b1;
        fork
            begin
                repeat (3 * LATENCY) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            repeat (2 * LATENCY) send_random_pixel();
        join
        // pause until every point is out, then resume
        pix.valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (30) send_random_pixel();
    endtask

    initial begin
        cam_cx = dp3d_pkg::RST_CENTER_X;
        cam_cy = dp3d_pkg::RST_CENTER_Y;
        cam_fx = dp3d_pkg::RST_FOCAL_X;
        cam_fy = dp3d_pkg::RST_FOCAL_Y;
        cam_scale = dp3d_pkg::RST_DEPTH_SCALE;
        cam_width = dp3d_pkg::RST_FRAME_WIDTH;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_camera(5090, 3725, 8382, 8387, 1000, 640);
        test_random_phase(75, 0, 0);
        write_camera($urandom_range(16383), $urandom_range(16383), $urandom_range(65535, 1),
                     $urandom_range(65535, 1), $urandom_range(65535, 1),
                     $urandom_range(1024, 1));
        test_random_phase(75, 66, 0);
        write_camera(16383, 16383, 16, 16, 16, 1024);
        test_random_phase(75, 0, 66);
        write_camera($urandom_range(16383), $urandom_range(16383), $urandom_range(20000, 1),
                     $urandom_range(20000, 1), $urandom_range(5000, 1),
                     $urandom_range(1024, 1));
        test_random_phase(75, 16, 16);
        test_backpressure();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (mismatches == 0 && expected_points.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/dp3d_pkg.sv
hw/rtl/dp3d_if.sv
hw/rtl/dp3d_div.sv
hw/rtl/depth_pixel_to_3d_point.sv
sim/tb_if.sv
sim/tb.sv
